/* rtl/lmis_pkg.sv */
// Shared types and constants for the line marker indent stripper.
`timescale 1ns / 1ps

package lmis_pkg;

  localparam int MARKER_SLOTS = 8;   // bytes held by the marker register
  localparam int MARKER_MAX   = 8;   // longest usable marker
  localparam int QCOUNT_W     = 3;   // width of a replay count (0..7)

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Configuration register indexes
  localparam logic [7:0] REG_MARKER_BYTES  = 8'd0;
  localparam logic [7:0] REG_MARKER_LENGTH = 8'd1;

  typedef logic [MARKER_SLOTS-1:0][7:0] marker_t;

  // Effective configuration seen by front and back
  typedef struct packed {
    marker_t    marker;
    logic [3:0] len;      // clamped to MARKER_MAX
  } cfg_t;

  // What closes an output job after its replayed marker bytes
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_BYTE,
    FIN_END
  } fin_t;

  // One queued job: replay rep_cnt marker bytes, then the closing result
  typedef struct packed {
    logic [QCOUNT_W-1:0] rep_cnt;
    fin_t                fin;
    logic [7:0]          data;
  } job_t;

endpackage

/* rtl/line_marker_indent_stripper.sv */
// Top level of the line marker indent stripper: config registers, front, queue and back.
`timescale 1ns / 1ps

// Byte-stream filter that strips a marker string found at the start of a line.
// Input stream: s_tdata carries one text byte, s_tuser marks end of text (no
// byte carried). Output stream: m_tdata is the passed byte, m_tuser marks the
// end result, m_tlast marks the final result caused by one input transfer.
// Config: cfg_index 0 writes the 64-bit marker (first char in low byte),
// index 1 writes the marker length (0 = pass-through); other indexes are
// dropped. cfg_ready is always high; write only while the stream is idle.
// Path: an input byte goes through the job queue, then the output register, to m_tdata.
// Throughput: one byte per cycle while s_tready is high; a failed partial marker of k
// bytes makes the output side emit k extra results through the single output register.
// The 4-entry job queue absorbs that, so s_tready only drops when it fills.
// Inputs that only advance a match or drop a byte produce no output.
// Reset clears the config registers, match state and queue; line start is set.
// When the receiver stalls, the output register holds its result and the
// queue keeps taking input until it is full.
module line_marker_indent_stripper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] text_byte
  input  logic        s_tuser,    // [0] end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] out_byte
  output logic        m_tuser,    // [0] is_end
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import lmis_pkg::*;

  logic [63:0] marker_bytes;
  logic [3:0]  marker_length;
  cfg_t        cfg;

  logic q_push, q_pop, q_full, q_valid;
  job_t push_job, head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_bytes  <= '0;
      marker_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MARKER_BYTES:  marker_bytes  <= cfg_data;
        REG_MARKER_LENGTH: marker_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg.marker = marker_bytes;
  assign cfg.len    = (marker_length > 4'(MARKER_MAX)) ? 4'(MARKER_MAX) : marker_length;

  lmis_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_end   (s_tuser),
    .q_full   (q_full),
    .push     (q_push),
    .job      (push_job)
  );

  lmis_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  lmis_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

/* rtl/lmis_front.sv */
// Front end: tracks line start and marker match state, turns each input into an output job.
`timescale 1ns / 1ps

module lmis_front (
  input  logic           clk,
  input  logic           rst,
  input  lmis_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_end,
  input  logic           q_full,
  output logic           push,
  output lmis_pkg::job_t job
);
  import lmis_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_MATCHING,
    MODE_AFTER,
    MODE_SKIPPING
  } mode_t;

  mode_t      mode, mode_next;
  logic       line_start, line_start_next;
  logic [3:0] matched, matched_next;
  logic [7:0] skip_char, skip_char_next;

  logic                accept;
  logic                take_normal;
  logic                take_after;
  logic                ls_cur;
  logic [3:0]          matched_inc;
  logic [QCOUNT_W-1:0] rep_capped;
  logic [QCOUNT_W-1:0] prev_idx;
  job_t                job_c;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mode_next       = mode;
    line_start_next = line_start;
    matched_next    = matched;
    skip_char_next  = skip_char;
    take_normal     = 1'b0;
    take_after      = 1'b0;
    ls_cur          = line_start;
    matched_inc     = matched + 4'd1;
    rep_capped      = matched[3] ? {QCOUNT_W{1'b1}} : matched[QCOUNT_W-1:0];
    prev_idx        = rep_capped - QCOUNT_W'(1);
    job_c.rep_cnt   = '0;
    job_c.fin       = FIN_NONE;
    job_c.data      = in_byte;

    if (in_end) begin
      if (mode == MODE_MATCHING) job_c.rep_cnt = rep_capped;
      job_c.fin       = FIN_END;
      job_c.data      = CHAR_NUL;
      mode_next       = MODE_NORMAL;
      line_start_next = 1'b1;
      matched_next    = '0;
      skip_char_next  = '0;
    end else if (cfg.len == 4'd0) begin
      // pass-through; flush anything matched under the old marker
      if (mode == MODE_MATCHING) job_c.rep_cnt = rep_capped;
      mode_next       = MODE_NORMAL;
      matched_next    = '0;
      job_c.fin       = FIN_BYTE;
      line_start_next = (in_byte == CHAR_NL);
    end else begin
      unique case (mode)
        MODE_MATCHING: begin
          if (matched >= cfg.len) begin
            take_after = 1'b1;
          end else if (in_byte == cfg.marker[matched[QCOUNT_W-1:0]]) begin
            matched_next = matched_inc;
            if (matched_inc >= cfg.len) mode_next = MODE_AFTER;
          end else begin
            job_c.rep_cnt = rep_capped;
            ls_cur        = (matched != 4'd0) && (cfg.marker[prev_idx] == CHAR_NL);
            matched_next  = '0;
            mode_next     = MODE_NORMAL;
            take_normal   = 1'b1;
          end
        end
        MODE_AFTER: take_after = 1'b1;
        MODE_SKIPPING: begin
          if (in_byte != skip_char) begin
            mode_next   = MODE_NORMAL;
            ls_cur      = 1'b0;
            take_normal = 1'b1;
          end
        end
        MODE_NORMAL: take_normal = 1'b1;
      endcase

      if (take_after) begin
        matched_next = '0;
        if (in_byte == CHAR_NL) begin
          job_c.fin       = FIN_BYTE;
          line_start_next = 1'b1;
          mode_next       = MODE_NORMAL;
        end else begin
          skip_char_next  = in_byte;
          line_start_next = 1'b0;
          mode_next       = MODE_SKIPPING;
        end
      end

      if (take_normal) begin
        if (ls_cur && in_byte == cfg.marker[0]) begin
          line_start_next = 1'b0;
          matched_next    = 4'd1;
          mode_next       = (cfg.len == 4'd1) ? MODE_AFTER : MODE_MATCHING;
        end else begin
          job_c.fin       = FIN_BYTE;
          line_start_next = (in_byte == CHAR_NL);
        end
      end
    end
  end

  assign job  = job_c;
  assign push = accept && (job_c.rep_cnt != '0 || job_c.fin != FIN_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      line_start <= 1'b1;
      matched    <= '0;
      skip_char  <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      line_start <= line_start_next;
      matched    <= matched_next;
      skip_char  <= skip_char_next;
    end
  end

endmodule

/* rtl/lmis_queue.sv */
// Small job queue between front and back.
`timescale 1ns / 1ps

module lmis_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lmis_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output lmis_pkg::job_t head_job
);
  import lmis_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

/* rtl/lmis_back.sv */
// Back end: expands queued jobs into output results through the output register.
`timescale 1ns / 1ps

module lmis_back (
  input  logic           clk,
  input  logic           rst,
  input  lmis_pkg::cfg_t cfg,
  input  logic           head_valid,
  input  lmis_pkg::job_t head_job,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tuser,
  output logic           m_tlast
);
  import lmis_pkg::*;

  logic [QCOUNT_W-1:0] idx, idx_next;
  logic                step;
  logic                in_replay;
  logic                has_fin;
  logic                job_done;
  logic [7:0]          res_data;
  logic                res_end;
  logic                res_last;

  assign step = head_valid && (!m_tvalid || m_tready);

  always_comb begin
    in_replay = (idx < head_job.rep_cnt);
    has_fin   = (head_job.fin != FIN_NONE);
    if (in_replay) begin
      res_data = cfg.marker[idx];
      res_end  = 1'b0;
      res_last = ({1'b0, idx} + 4'd1 == {1'b0, head_job.rep_cnt}) && !has_fin;
      job_done = res_last;
    end else begin
      res_end  = (head_job.fin == FIN_END);
      res_data = res_end ? CHAR_NUL : head_job.data;
      res_last = 1'b1;
      job_done = 1'b1;
    end
    idx_next = idx;
    if (step) idx_next = job_done ? '0 : idx + QCOUNT_W'(1);
  end

  assign pop = step && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (step)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= res_data;
      m_tuser <= res_end;
      m_tlast <= res_last;
    end
  end

endmodule

/* rtl/lmis_checker.sv */
// Port-level checks for the line marker indent stripper, bound to the top level.
`timescale 1ns / 1ps

module lmis_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  // output register is empty and the queue takes input right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output valid or input stall right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled output transfer changed");

  // the end result carries no byte and closes its run
  a_end_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'h00 && m_tlast)
    else $error("end result malformed");

  // the cycle after reset ends, nothing has had time to reach the output
  a_no_early_out: assert property (@(posedge clk) $fell(rst) |-> !m_tvalid)
    else $error("output valid before any input could arrive");

endmodule

bind line_marker_indent_stripper lmis_checker u_lmis_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* tb/sv/testbench.sv */
// Testbench for line_marker_indent_stripper: directed table, random text lines, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import lmis_pkg::*;

  localparam int DRAIN        = 10;      // cycles after the last result before a config write
  localparam int HOLD_CYCLES  = 150;     // long receiver hold-off
  localparam int ITEM_TARGET  = 200;     // directed plus random text items
  localparam int LIMIT        = 400000;
  localparam logic [7:0] REG_SPARE = 8'd2;  // beyond the register list, must be ignored

  typedef enum logic [1:0] {
    FM_NORMAL,
    FM_MATCHING,
    FM_AFTER,
    FM_SKIPPING
  } filter_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       last;
  } out_beat_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_TEXT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  val;       // text byte, or register index for ROW_CFG
    logic        eot;
    logic [63:0] wdata;
    logic [7:0]  exp_data;
    logic        exp_end;
  } stim_row_t;

  localparam stim_row_t PLAN [32] = '{
    // pass-through after reset
    '{ROW_TYPED, 8'h00,   1'b0, 64'h0, 8'h00,   1'b0},
    '{ROW_TYPED, 8'hFF,   1'b0, 64'h0, 8'hFF,   1'b0},
    '{ROW_TYPED, CHAR_NL, 1'b0, 64'h0, CHAR_NL, 1'b0},
    '{ROW_TYPED, 8'h00,   1'b1, 64'h0, CHAR_NUL, 1'b1},
    // two-byte marker "#%"
    '{ROW_CFG, REG_MARKER_BYTES,  1'b0, 64'h2523, 8'h00, 1'b0},
    '{ROW_CFG, REG_MARKER_LENGTH, 1'b0, 64'd2,    8'h00, 1'b0},
    '{ROW_TEXT, 8'h23,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h25,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h20,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h78,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, CHAR_NL, 1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_CFG, REG_SPARE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0},
    // partial marker replayed
    '{ROW_TEXT, 8'h23,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h78,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h00,   1'b1, 64'h0, 8'h00, 1'b0},
    // marker then newline
    '{ROW_TEXT, 8'h23,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h25,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, CHAR_NL, 1'b0, 64'h0, 8'h00, 1'b0},
    // partial marker flushed by end of text
    '{ROW_TEXT, 8'h23,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h5A,   1'b1, 64'h0, 8'h00, 1'b0},
    // marker holding a newline, length above the maximum
    '{ROW_CFG, REG_MARKER_BYTES,  1'b0, 64'h4141_4141_4141_0A23, 8'h00, 1'b0},
    '{ROW_CFG, REG_MARKER_LENGTH, 1'b0, 64'd15, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h23,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, CHAR_NL, 1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h51,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, CHAR_NL, 1'b0, 64'h0, 8'h00, 1'b0},
    // one-byte marker, skipped run of the marker char itself
    '{ROW_CFG, REG_MARKER_LENGTH, 1'b0, 64'd1, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h23,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h23,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h23,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h79,   1'b0, 64'h0, 8'h00, 1'b0},
    '{ROW_TEXT, 8'h00,   1'b1, 64'h0, 8'h00, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [63:0] cfg_data;

  // predictor copy of config and filter state
  marker_t      pm_marker;
  logic [3:0]   pm_len_reg;
  filter_mode_e pm_mode;
  logic         pm_line_start;
  logic [3:0]   pm_matched;
  logic [7:0]   pm_skip;

  out_beat_t step_beats[$];
  out_beat_t filtered_q[$];
  out_beat_t got, want;

  int  err_count = 0;
  int  items_sent = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;

  line_marker_indent_stripper u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [3:0] eff_len();
    return (pm_len_reg > MARKER_MAX) ? 4'(MARKER_MAX) : pm_len_reg;
  endfunction

  task automatic push_beat(input logic [7:0] d, input logic e);
    out_beat_t bt;
    bt.data   = d;
    bt.is_end = e;
    bt.last   = 1'b0;
    step_beats.push_back(bt);
  endtask

  task automatic replay_marker();
    int n;
    n = (pm_matched > 4'd7) ? 7 : int'(pm_matched);
    for (int i = 0; i < n; i++) push_beat(pm_marker[i], 1'b0);
  endtask

  // Results caused by one text transfer, left in step_beats.
  task automatic strip_byte(input logic [7:0] b, input logic eot);
    logic [3:0] len;
    logic       run_normal;
    logic       run_after;
    out_beat_t  tail;
    len = eff_len();
    run_normal = 1'b0;
    run_after = 1'b0;
    step_beats.delete();
    if (eot) begin
      if (pm_mode == FM_MATCHING) replay_marker();
      push_beat(CHAR_NUL, 1'b1);
      pm_mode = FM_NORMAL;
      pm_line_start = 1'b1;
      pm_matched = '0;
      pm_skip = '0;
    end else if (len == 4'd0) begin
      if (pm_mode == FM_MATCHING) replay_marker();
      pm_mode = FM_NORMAL;
      pm_matched = '0;
      push_beat(b, 1'b0);
      pm_line_start = (b == CHAR_NL);
    end else begin
      case (pm_mode)
        FM_MATCHING: begin
          if (pm_matched >= len) begin
            // length shrunk below the match: marker counts as complete
            run_after = 1'b1;
          end else if (b == pm_marker[pm_matched[2:0]]) begin
            pm_matched = pm_matched + 4'd1;
            if (pm_matched >= len) pm_mode = FM_AFTER;
          end else begin
            replay_marker();
            pm_line_start = (pm_matched > 4'd0) &&
                            (pm_marker[3'(pm_matched - 4'd1)] == CHAR_NL);
            pm_matched = '0;
            pm_mode = FM_NORMAL;
            run_normal = 1'b1;
          end
        end
        FM_AFTER: run_after = 1'b1;
        FM_SKIPPING: begin
          if (b != pm_skip) begin
            pm_mode = FM_NORMAL;
            pm_line_start = 1'b0;
            run_normal = 1'b1;
          end
        end
        default: run_normal = 1'b1;
      endcase
      if (run_after) begin
        pm_matched = '0;
        if (b == CHAR_NL) begin
          push_beat(b, 1'b0);
          pm_line_start = 1'b1;
          pm_mode = FM_NORMAL;
        end else begin
          pm_skip = b;
          pm_line_start = 1'b0;
          pm_mode = FM_SKIPPING;
        end
      end
      if (run_normal) begin
        if (pm_line_start && b == pm_marker[0]) begin
          pm_line_start = 1'b0;
          pm_matched = 4'd1;
          if (len == 4'd1) pm_mode = FM_AFTER;
          else pm_mode = FM_MATCHING;
        end else begin
          push_beat(b, 1'b0);
          pm_line_start = (b == CHAR_NL);
        end
      end
    end
    if (step_beats.size() > 0) begin
      tail = step_beats.pop_back();
      tail.last = 1'b1;
      step_beats.push_back(tail);
    end
  endtask

  // Drop valid, wait out every pending result, then let the pipeline settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MARKER_BYTES) pm_marker = val;
    else if (idx == REG_MARKER_LENGTH) pm_len_reg = val[3:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [7:0] d, input logic e,
                           input logic typed, input out_beat_t typed_beat);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= e;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    strip_byte(d, e);
    if (typed) filtered_q.push_back(typed_beat);
    else foreach (step_beats[i]) filtered_q.push_back(step_beats[i]);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(b, 1'b0, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 8'($urandom_range(0, 255));
    if (roll < 60) return pm_marker[$urandom_range(0, 7)];
    if (roll < 70) return CHAR_NL;
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  task automatic random_config(input int ph);
    int          roll;
    logic [63:0] mk;
    logic [3:0]  ln;
    roll = $urandom_range(0, 99);
    mk = {$urandom, $urandom};
    if (roll < 15) mk = '0;
    else if (roll < 25) mk = '1;
    else if (roll >= 55)
      for (int i = 0; i < MARKER_SLOTS; i++) mk[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
    roll = $urandom_range(0, 99);
    if (roll < 10) ln = 4'd0;
    else if (roll < 25) ln = 4'($urandom_range(8, 15));
    else ln = 4'($urandom_range(1, 7));
    if (ph == 0) begin
      mk = '1;
      ln = 4'(MARKER_MAX);
    end
    if (ph == 0 || $urandom_range(0, 99) < 70) write_reg(REG_MARKER_BYTES, mk);
    // upper data bits are don't-care for the length register
    write_reg(REG_MARKER_LENGTH, {$urandom, 28'($urandom_range(0, 268435455)), ln});
    if ($urandom_range(0, 99) < 15) write_reg(8'($urandom_range(2, 255)), {$urandom, $urandom});
  endtask

  // One text line, mostly shaped around the current marker.
  task automatic send_line();
    int         kind;
    int         n;
    int         j;
    logic [3:0] len;
    logic [7:0] b;
    len = eff_len();
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      for (int i = 0; i < len; i++) send_byte(pm_marker[i]);
      if ($urandom_range(0, 3) == 0) begin
        send_byte(CHAR_NL);
        return;
      end
      b = pick_byte();
      n = $urandom_range(1, 4);
      repeat (n) send_byte(b);
    end else if (kind < 65 && len >= 4'd2) begin
      j = $urandom_range(1, len - 1);
      for (int i = 0; i < j; i++) send_byte(pm_marker[i]);
      b = pick_byte();
      if (b == pm_marker[j]) b = b ^ 8'h01;
      send_byte(b);
    end else if (kind >= 88) begin
      // noise, sometimes cut off by end of text
      n = $urandom_range(1, 6);
      repeat (n) send_byte(pick_byte());
      if ($urandom_range(0, 2) == 0) send_item(8'($urandom), 1'b1, 1'b0, '0);
      return;
    end
    n = $urandom_range(0, 6);
    repeat (n) send_byte(pick_byte());
    if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b1, 1'b0, '0);
    else send_byte(CHAR_NL);
  endtask

  initial begin : stimulus
    out_beat_t typed_beat;
    int        ph;
    int        target;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pm_marker = '0;
    pm_len_reg = '0;
    pm_mode = FM_NORMAL;
    pm_line_start = 1'b1;
    pm_matched = '0;
    pm_skip = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (PLAN[r]) begin
      case (PLAN[r].kind)
        ROW_CFG: write_reg(PLAN[r].val, PLAN[r].wdata);
        ROW_TEXT: send_item(PLAN[r].val, PLAN[r].eot, 1'b0, '0);
        default: begin
          typed_beat = {PLAN[r].exp_data, PLAN[r].exp_end, 1'b1};
          send_item(PLAN[r].val, PLAN[r].eot, 1'b1, typed_beat);
        end
      endcase
    end

    ph = 0;
    while (items_sent < ITEM_TARGET) begin
      random_config(ph);
      no_idle = (ph == 1);
      if (ph == 2) hold_req = 1'b1;
      target = items_sent + $urandom_range(15, 40);
      while (items_sent < target) send_line();
      ph++;
    end
    no_idle = 1'b0;

    wait_idle();
    if (err_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // Receiver: random backpressure, one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  task automatic note_error(input string what, input out_beat_t w, input out_beat_t g);
    err_count++;
    if (err_count <= 10)
      $display("%s: want data %02h end %0b last %0b, got data %02h end %0b last %0b",
               what, w.data, w.is_end, w.last, g.data, g.is_end, g.last);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata, m_tuser, m_tlast};
      if (filtered_q.size() == 0) begin
        note_error("unexpected transfer", '0, got);
      end else begin
        want = filtered_q.pop_front();
        if (got !== want) note_error("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

endmodule

/* filelist.f */
rtl/lmis_pkg.sv
rtl/lmis_front.sv
rtl/lmis_queue.sv
rtl/lmis_back.sv
rtl/line_marker_indent_stripper.sv
rtl/lmis_checker.sv
tb/sv/testbench.sv
